// ----- rtl/spnlc_pkg.sv -----
package spnlc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int NUM_KEYS    = 256;
	localparam int KEY_W       = 8;
	localparam int BIAS_W      = 16;
	localparam int NIB_KEYS    = 16;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	localparam logic [3:0] INV_SBOX [NIB_KEYS] = '{
		4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
		4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
	};

	typedef struct packed {
		logic shift;
		logic inc;
	} cell_ctl_t;

	typedef struct packed {
		logic             step;
		logic             first;
		logic [KEY_W-1:0] idx;
	} scan_ctl_t;

	// parity of inverse s-box output bits 2 and 0
	function automatic logic par02(input logic [3:0] nib);
		logic [3:0] u;
		u = INV_SBOX[nib];
		return u[2] ^ u[0];
	endfunction

	function automatic logic [BIAS_W-1:0] sat_bias(input logic [COUNT_WIDTH-1:0] d);
		logic [BIAS_W-1:0] r;
		if (d > COUNT_WIDTH'({BIAS_W{1'b1}})) begin
			r = '1;
		end else begin
			r = BIAS_W'(d);
		end
		return r;
	endfunction

endpackage

// ----- rtl/spnlc_ifs.sv -----
interface spnlc_pair_if;
	logic        valid;
	logic        ready;
	logic [15:0] plaintext;
	logic [15:0] ciphertext;
	logic        last_pair;

	modport source (output valid, plaintext, ciphertext, last_pair, input ready);
	modport sink (input valid, plaintext, ciphertext, last_pair, output ready);
endinterface

interface spnlc_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  best_key;
	logic [15:0] bias_magnitude;
	logic        count_overflow;

	modport source (output valid, best_key, bias_magnitude, count_overflow, input ready);
	modport sink (input valid, best_key, bias_magnitude, count_overflow, output ready);
endinterface

// ----- rtl/spnlc_cell.sv -----
module spnlc_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spnlc_pkg::cell_ctl_t               ctl,
	input  logic                               hit,
	input  logic [spnlc_pkg::COUNT_WIDTH-1:0]  nbr,
	output logic [spnlc_pkg::COUNT_WIDTH-1:0]  cnt
);

	logic [spnlc_pkg::COUNT_WIDTH-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.shift) begin
			cnt_q <= nbr;
		end else if (ctl.inc && hit && (cnt_q != spnlc_pkg::CNT_MAX)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign cnt = cnt_q;

endmodule

// ----- rtl/spnlc_scan.sv -----
module spnlc_scan (
	input  logic                               clk,
	input  spnlc_pkg::scan_ctl_t               ctl,
	input  logic [spnlc_pkg::COUNT_WIDTH-1:0]  cnt,
	input  logic [spnlc_pkg::COUNT_WIDTH-1:0]  half,
	output logic [spnlc_pkg::KEY_W-1:0]        key,
	output logic [spnlc_pkg::BIAS_W-1:0]       bias
);

	logic [spnlc_pkg::COUNT_WIDTH-1:0] d;
	logic [spnlc_pkg::COUNT_WIDTH-1:0] best_q;
	logic [spnlc_pkg::KEY_W-1:0]       key_q;

	assign d = (cnt >= half) ? (cnt - half) : (half - cnt);

	// strict greater keeps the first key on ties
	always_ff @(posedge clk) begin
		if (ctl.step && (ctl.first || (d > best_q))) begin
			best_q <= d;
			key_q  <= ctl.idx;
		end
	end

	assign key  = key_q;
	assign bias = spnlc_pkg::sat_bias(best_q);

endmodule

// ----- rtl/spn_linear_attack_key_counter_unit.sv -----
// a set's result follows its last pair through the pair stage, shift-out and report
// throughput: one pair per cycle while counting; each set then blocks the input for the
//   counter chain shift-out and report, longer while an earlier result waits
// reset: arst_n clears all counters, the pair total and the overflow flag at once
// the shift-out leaves the counters cleared for the next set
module spn_linear_attack_key_counter_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	spnlc_pair_if.sink            pair,
	spnlc_result_if.source        result
);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SCAN,
		ST_REPORT
	} state_t;

	state_t                                state_q;
	logic [spnlc_pkg::KEY_W-1:0]           idx_q;
	logic [spnlc_pkg::COUNT_WIDTH-1:0]     pair_total_q;
	logic                                  overflow_q;
	logic                                  out_valid_q;
	logic [spnlc_pkg::KEY_W-1:0]           out_key_q;
	logic [spnlc_pkg::BIAS_W-1:0]          out_bias_q;
	logic                                  out_ovf_q;

	logic                                  valid_s1;
	logic                                  last_s1;
	logic                                  inc_s1;
	logic                                  pb_s1;
	logic [spnlc_pkg::NIB_KEYS-1:0]        hp_s1;
	logic [spnlc_pkg::NIB_KEYS-1:0]        lp_s1;

	logic                                  acc;
	logic                                  full;
	logic [spnlc_pkg::NIB_KEYS-1:0]        hp_d;
	logic [spnlc_pkg::NIB_KEYS-1:0]        lp_d;
	logic                                  out_free;
	logic [spnlc_pkg::NUM_KEYS-1:0]        hit;
	logic [spnlc_pkg::COUNT_WIDTH-1:0]     cnt [spnlc_pkg::NUM_KEYS];
	spnlc_pkg::cell_ctl_t                  cell_ctl;
	spnlc_pkg::scan_ctl_t                  scan_ctl;
	logic [spnlc_pkg::KEY_W-1:0]           scan_key;
	logic [spnlc_pkg::BIAS_W-1:0]          scan_bias;

	assign pair.ready = (state_q == ST_COLLECT) && !(valid_s1 && last_s1);
	assign acc        = pair.valid && pair.ready;
	assign full       = (pair_total_q == spnlc_pkg::CNT_MAX);
	assign out_free   = !out_valid_q || result.ready;

	always_comb begin
		for (int i = 0; i < spnlc_pkg::NIB_KEYS; i++) begin
			hp_d[i] = spnlc_pkg::par02(pair.ciphertext[11:8] ^ 4'(i));
			lp_d[i] = spnlc_pkg::par02(pair.ciphertext[3:0] ^ 4'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			inc_s1   <= 1'b0;
		end else begin
			valid_s1 <= acc;
			last_s1  <= acc && pair.last_pair;
			inc_s1   <= acc && !full;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pb_s1 <= pair.plaintext[11] ^ pair.plaintext[9] ^ pair.plaintext[8];
			hp_s1 <= hp_d;
			lp_s1 <= lp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COLLECT;
			idx_q        <= '0;
			pair_total_q <= '0;
			overflow_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_key_q    <= '0;
			out_bias_q   <= '0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && (state_q != ST_REPORT)) begin
				out_valid_q <= 1'b0;
			end
			if (acc) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					pair_total_q <= pair_total_q + 1'b1;
				end
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (valid_s1 && last_s1) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == spnlc_pkg::KEY_W'(spnlc_pkg::NUM_KEYS - 1)) begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_key_q    <= scan_key;
						out_bias_q   <= scan_bias;
						out_ovf_q    <= overflow_q;
						pair_total_q <= '0;
						overflow_q   <= 1'b0;
						state_q      <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign cell_ctl.shift = (state_q == ST_SCAN);
	assign cell_ctl.inc   = inc_s1;

	genvar k;
	generate
		for (k = 0; k < spnlc_pkg::NUM_KEYS; k++) begin : g_cell
			logic [spnlc_pkg::COUNT_WIDTH-1:0] nbr;
			if (k == spnlc_pkg::NUM_KEYS - 1) begin : g_tail
				assign nbr = '0;
			end else begin : g_link
				assign nbr = cnt[k + 1];
			end
			assign hit[k] = ~(pb_s1 ^ hp_s1[k / spnlc_pkg::NIB_KEYS]
				^ lp_s1[k % spnlc_pkg::NIB_KEYS]);
			spnlc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.hit    (hit[k]),
				.nbr    (nbr),
				.cnt    (cnt[k])
			);
		end
	endgenerate

	assign scan_ctl.step  = (state_q == ST_SCAN);
	assign scan_ctl.first = (idx_q == '0);
	assign scan_ctl.idx   = idx_q;

	spnlc_scan u_scan (
		.clk  (clk),
		.ctl  (scan_ctl),
		.cnt  (cnt[0]),
		.half (pair_total_q >> 1),
		.key  (scan_key),
		.bias (scan_bias)
	);

	assign result.valid          = out_valid_q;
	assign result.best_key       = out_key_q;
	assign result.bias_magnitude = out_bias_q;
	assign result.count_overflow = out_ovf_q;

	a_rose_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_REPORT))
		else $error("result appeared outside report");

	a_chain_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> (cnt[0] == '0 && cnt[spnlc_pkg::NUM_KEYS - 1] == '0))
		else $error("counter chain not cleared after scan");

	a_totals_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q == ST_REPORT) && state_q == ST_COLLECT) |->
		(pair_total_q == '0 && !overflow_q))
		else $error("pair total not cleared after report");

	a_no_count_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (!inc_s1 && !valid_s1))
		else $error("pair reached cells during scan");

endmodule
